>>> design/g4trp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g4trp_pkg
// Shared constants, types and helper functions of the gray4 row packer.
// ----------------------------------------------------------------------------
package g4trp_pkg;

	// row cache geometry
	localparam int SLOT_W     = 4;
	localparam int CACHE_ROWS = 1 << SLOT_W;
	localparam int MAX_WIDTH  = 128;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ADDR_W     = SLOT_W + COL_W;
	localparam int DEPTH      = CACHE_ROWS << COL_W;

	// field widths
	localparam int COORD_W = 12;
	localparam int COLOR_W = 16;
	localparam int CW_W    = 8;
	localparam int CH_W    = 12;
	localparam int CFG_W   = 12;
	localparam int IDX_W   = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_AVG    = 2'd2;

	// register reset values
	localparam logic [CW_W-1:0] WIDTH_RST  = 8'd128;
	localparam logic [CH_W-1:0] HEIGHT_RST = 12'd96;

	// gray scaling: sum / 1600 == (sum * GRAY_RECIP) >> GRAY_SHIFT for sum <= 25500
	localparam logic [15:0] GRAY_RECIP = 16'd41944;
	localparam int          GRAY_SHIFT = 26;

	typedef struct packed {
		logic [CW_W-1:0] width;
		logic [CH_W-1:0] height;
		logic            avg;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic [COORD_W-1:0] row;
		logic [3:0]         gray;
		logic               row_ok;
		logic               col_ok;
	} ent_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_t;

	// width register to the width in use
	function automatic logic [CW_W-1:0] eff_width(input logic [CW_W-1:0] dw);
		logic [CW_W-1:0] w;
		if (dw == '0) begin
			w = CW_W'(1);
		end else if ({24'd0, dw} > MAX_WIDTH) begin
			w = CW_W'(MAX_WIDTH);
		end else begin
			w = dw;
		end
		return w;
	endfunction

	// c * 255 / 31 == 8c + floor(7c / 31), floor(n / 31) == (n * 529) >> 14
	function automatic logic [7:0] chan5_to_8(input logic [4:0] c);
		logic [7:0]  n;
		logic [17:0] p;
		n = {c, 3'b000} - {3'b000, c};
		p = 18'(n) * 18'd529;
		return {c, 3'b000} + {5'd0, p[16:14]};
	endfunction

	// c * 255 / 63 == 4c + floor(c / 21), floor(c / 21) == (c * 49) >> 10
	function automatic logic [7:0] chan6_to_8(input logic [5:0] c);
		logic [11:0] p;
		p = 12'(c) * 12'd49;
		return {c, 2'b00} + {6'd0, p[11:10]};
	endfunction

endpackage

>>> design/g4trp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g4trp_front
// Accepts pixels, classifies them against the image size and converts the
// color to 4-bit gray in three stages, then queues them for the back end.
// ----------------------------------------------------------------------------
module g4trp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  g4trp_pkg::cfg_t               cfg,
	input  logic                          push,
	output logic                          full,
	input  logic [g4trp_pkg::COORD_W-1:0] pixel_x,
	input  logic [g4trp_pkg::COORD_W-1:0] pixel_y,
	input  logic [g4trp_pkg::COLOR_W-1:0] color,
	output logic                          ent_valid,
	output g4trp_pkg::ent_t               ent,
	input  logic                          ent_pop
);

	logic            v_s1, v_s2, v_s3;
	logic [7:0]      r8_s1, g8_s1, b8_s1;
	logic [14:0]     sum_s2;
	g4trp_pkg::ent_t e_s1, e_s2, e_s3;
	logic            mv1, mv2, mv3, take;
	logic [30:0]     prod;
	g4trp_pkg::ent_t q_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;

	// stage moves
	assign mv3  = v_s3 && (cnt_q != 2'd2);
	assign mv2  = v_s2 && (!v_s3 || mv3);
	assign mv1  = v_s1 && (!v_s2 || mv2);
	assign full = v_s1 && !mv1;
	assign take = push && !full;
	assign prod = 31'(sum_s2) * 31'(g4trp_pkg::GRAY_RECIP);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take) v_s1 <= 1'b1;
			else if (mv1) v_s1 <= 1'b0;
			if (mv1) v_s2 <= 1'b1;
			else if (mv2) v_s2 <= 1'b0;
			if (mv2) v_s3 <= 1'b1;
			else if (mv3) v_s3 <= 1'b0;
		end
	end

	// stage 1: classify and expand channels
	always_ff @(posedge clk) begin
		if (take) begin
			r8_s1       <= g4trp_pkg::chan5_to_8(color[15:11]);
			g8_s1       <= g4trp_pkg::chan6_to_8(color[10:5]);
			b8_s1       <= g4trp_pkg::chan5_to_8(color[4:0]);
			e_s1.col    <= pixel_x[g4trp_pkg::COL_W-1:0];
			e_s1.row    <= pixel_y;
			e_s1.gray   <= 4'd0;
			e_s1.row_ok <= pixel_y < cfg.height;
			e_s1.col_ok <= pixel_x < {4'd0, cfg.width};
		end
	end

	// stage 2: weighted sum
	always_ff @(posedge clk) begin
		if (mv1) begin
			sum_s2 <= 15'(r8_s1) * 15'd30 + 15'(g8_s1) * 15'd59 + 15'(b8_s1) * 15'd11;
			e_s2   <= e_s1;
		end
	end

	// stage 3: scale to four bits
	always_ff @(posedge clk) begin
		if (mv2) begin
			e_s3 <= {e_s2.col, e_s2.row,
				prod[g4trp_pkg::GRAY_SHIFT+3:g4trp_pkg::GRAY_SHIFT],
				e_s2.row_ok, e_s2.col_ok};
		end
	end

	// two-entry item queue to the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (mv3) wp_q <= !wp_q;
			if (ent_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, mv3} - {1'b0, ent_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (mv3) q_q[wp_q] <= e_s3;
	end

	assign ent_valid = cnt_q != 2'd0;
	assign ent       = q_q[rp_q];

endmodule

>>> design/g4trp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g4trp_back
// Keeps the tagged row cache, stores gray values and, when the next row
// group is complete, reads it back and packs it into bytes.
// ----------------------------------------------------------------------------
module g4trp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  g4trp_pkg::cfg_t cfg,
	input  logic            ent_valid,
	input  g4trp_pkg::ent_t ent,
	output logic            ent_pop,
	input  logic            oq_full,
	output logic            oq_push,
	output g4trp_pkg::out_t oq_data
);

	localparam int SW = g4trp_pkg::SLOT_W;
	localparam int CW = g4trp_pkg::COL_W;
	localparam int AW = g4trp_pkg::ADDR_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOOK   = 4'd1;
	localparam logic [3:0] ST_CLEAR  = 4'd2;
	localparam logic [3:0] ST_MARK   = 4'd3;
	localparam logic [3:0] ST_MARKW  = 4'd4;
	localparam logic [3:0] ST_CHECK  = 4'd5;
	localparam logic [3:0] ST_CHECK2 = 4'd6;
	localparam logic [3:0] ST_RD     = 4'd7;
	localparam logic [3:0] ST_ACC    = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0]      state_q;
	g4trp_pkg::ent_t e_q;
	logic [11:0]     nor_q;
	logic [CW-1:0]   clr_q;
	logic [7:0]      xi_q;
	logic            nib_q;
	logic [1:0]      rd_q;
	logic [5:0]      acc_q;
	logic [3:0]      hi_q;

	logic [11:0] tag_q   [g4trp_pkg::CACHE_ROWS];
	logic        valid_q [g4trp_pkg::CACHE_ROWS];
	logic [7:0]  cnt_q   [g4trp_pkg::CACHE_ROWS];

	logic       mark_mem [g4trp_pkg::DEPTH];
	logic [3:0] gray_mem [g4trp_pkg::DEPTH];
	logic       mark_rd_q;
	logic [3:0] gray_rd_q;

	logic [SW-1:0] e_slot, s0, s1, ridx, rsel;
	logic [11:0]   want;
	logic          ready_r, fits, retag, store;
	logic [12:0]   need_end;
	logic [7:0]    half, step, c, c1, cn, col;
	logic [8:0]    xi_half, xi_step;
	logic [5:0]    a_sum;
	logic          last_rd, nib2_ok, byte_last;
	logic [3:0]    nibv;
	logic          mark_we;
	logic [AW-1:0] mark_wa, mark_ra, gray_ra;

	assign e_slot   = e_q.row[SW-1:0];
	assign s0       = nor_q[SW-1:0];
	assign s1       = s0 + SW'(1);
	assign half     = cfg.avg ? 8'd2 : 8'd1;
	assign step     = cfg.avg ? 8'd4 : 8'd2;
	assign need_end = {1'b0, nor_q} + (cfg.avg ? 13'd2 : 13'd1);
	assign fits     = need_end <= {1'b0, cfg.height};

	// one read index into the slot tables
	always_comb begin
		case (state_q)
			ST_CHECK: begin
				ridx = s0;
				want = nor_q;
			end
			ST_CHECK2: begin
				ridx = s1;
				want = nor_q + 12'd1;
			end
			default: begin
				ridx = e_slot;
				want = e_q.row;
			end
		endcase
	end

	assign ready_r = valid_q[ridx] && (tag_q[ridx] == want) && (cnt_q[ridx] == cfg.width);
	assign retag   = !valid_q[ridx] || (tag_q[ridx] != e_q.row);
	assign store   = !mark_rd_q && e_q.col_ok;

	// read address of the pack sequencer
	assign c      = xi_q + (nib_q ? half : 8'd0);
	assign c1     = c + 8'd1;
	assign cn     = (c1 < cfg.width) ? c1 : c;
	assign col    = (cfg.avg && rd_q[0]) ? cn : c;
	assign rsel   = (cfg.avg && rd_q[1]) ? s1 : s0;
	assign gray_ra = {rsel, col[CW-1:0]};

	// accumulate step
	assign a_sum     = acc_q + {2'b00, gray_rd_q};
	assign last_rd   = !cfg.avg || (rd_q == 2'd3);
	assign nibv      = cfg.avg ? a_sum[5:2] : a_sum[3:0];
	assign xi_half   = {1'b0, xi_q} + {1'b0, half};
	assign xi_step   = {1'b0, xi_q} + {1'b0, step};
	assign nib2_ok   = xi_half < {1'b0, cfg.width};
	assign byte_last = xi_step >= {1'b0, cfg.width};

	// mark memory port
	assign mark_we = (state_q == ST_CLEAR) || ((state_q == ST_MARKW) && store);
	assign mark_wa = (state_q == ST_CLEAR) ? {e_slot, clr_q} : {e_slot, e_q.col};
	assign mark_ra = {e_slot, e_q.col};

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_wa] <= (state_q == ST_MARKW);
		mark_rd_q <= mark_mem[mark_ra];
	end

	// gray memory port
	always_ff @(posedge clk) begin
		if ((state_q == ST_MARKW) && store) gray_mem[{e_slot, e_q.col}] <= e_q.gray;
		gray_rd_q <= gray_mem[gray_ra];
	end

	// output push
	always_comb begin
		oq_push      = 1'b0;
		oq_data.data = {hi_q, nibv};
		oq_data.last = byte_last;
		if ((state_q == ST_ACC) && last_rd) begin
			if (!nib_q && !nib2_ok) begin
				oq_push      = 1'b1;
				oq_data.data = {nibv, 4'd0};
			end else if (nib_q) begin
				oq_push = 1'b1;
			end
		end
	end

	assign ent_pop = (state_q == ST_IDLE) && ent_valid;

	// item payload and pack datapath
	always_ff @(posedge clk) begin
		if (ent_pop) e_q <= ent;
		case (state_q)
			ST_LOOK:  clr_q <= '0;
			ST_CLEAR: clr_q <= clr_q + CW'(1);
			ST_CHECK, ST_CHECK2: begin
				xi_q  <= 8'd0;
				nib_q <= 1'b0;
				rd_q  <= 2'd0;
				acc_q <= 6'd0;
			end
			ST_ACC: begin
				if (!last_rd) begin
					acc_q <= a_sum;
					rd_q  <= rd_q + 2'd1;
				end else begin
					acc_q <= 6'd0;
					rd_q  <= 2'd0;
					if (!nib_q && nib2_ok) begin
						hi_q  <= nibv;
						nib_q <= 1'b1;
					end else begin
						nib_q <= 1'b0;
						xi_q  <= xi_step[7:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control sequencer and slot tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nor_q   <= 12'd0;
			for (int i = 0; i < g4trp_pkg::CACHE_ROWS; i++) begin
				tag_q[i]   <= 12'd0;
				valid_q[i] <= 1'b0;
				cnt_q[i]   <= 8'd0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ent_valid) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (!e_q.row_ok) begin
						state_q <= ST_CHECK;
					end else if (retag) begin
						valid_q[e_slot] <= 1'b1;
						tag_q[e_slot]   <= e_q.row;
						cnt_q[e_slot]   <= 8'd0;
						state_q         <= ST_CLEAR;
					end else begin
						state_q <= e_q.col_ok ? ST_MARK : ST_CHECK;
					end
				end
				ST_CLEAR: begin
					if (clr_q == CW'(g4trp_pkg::MAX_WIDTH - 1)) begin
						state_q <= e_q.col_ok ? ST_MARK : ST_CHECK;
					end
				end
				ST_MARK: state_q <= ST_MARKW;
				ST_MARKW: begin
					if (store) cnt_q[e_slot] <= cnt_q[e_slot] + 8'd1;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!fits || !ready_r) state_q <= ST_IDLE;
					else state_q <= cfg.avg ? ST_CHECK2 : ST_RD;
				end
				ST_CHECK2: state_q <= ready_r ? ST_RD : ST_IDLE;
				ST_RD: begin
					if (nib_q || (rd_q != 2'd0) || !oq_full) state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (last_rd && (nib_q || !nib2_ok) && byte_last) state_q <= ST_DONE;
					else state_q <= ST_RD;
				end
				ST_DONE: begin
					valid_q[s0] <= 1'b0;
					tag_q[s0]   <= 12'd0;
					cnt_q[s0]   <= 8'd0;
					if (cfg.avg) begin
						valid_q[s1] <= 1'b0;
						tag_q[s1]   <= 12'd0;
						cnt_q[s1]   <= 8'd0;
					end
					nor_q   <= need_end[11:0];
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/g4trp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g4trp_outq
// Four-entry queue of packed bytes toward the receiver.
// ----------------------------------------------------------------------------
module g4trp_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  g4trp_pkg::out_t wdata,
	output logic            full,
	output logic            empty,
	input  logic            pop,
	output g4trp_pkg::out_t rdata
);

	g4trp_pkg::out_t mem_q [4];
	logic [1:0]      wp_q, rp_q;
	logic [2:0]      cnt_q;
	logic            rd;

	assign full  = cnt_q == 3'd4;
	assign empty = cnt_q == 3'd0;
	assign rd    = pop && !empty;
	assign rdata = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b00, wr} - {2'b00, rd};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

endmodule

>>> design/gray4_thumbnail_row_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray4_thumbnail_row_packer
// Converts RGB565 pixels to 4-bit gray in a tagged row cache and emits
// complete rows (or averaged row pairs) as packed nibble bytes.
// ----------------------------------------------------------------------------
// Usage: pixels enter on a queue-style port (push/full) with pixel_x, pixel_y
// and color; packed bytes leave on a queue-style port (empty/pop) with
// packed_byte and last_of_row set on the final byte of each output row.
// Registers width, height and average mode are written through cfg_we,
// cfg_index and cfg_data while the block is idle; the user must keep to this,
// as the block itself does not enforce it. A three-stage gray converter feeds
// a two-entry queue; the back end takes one item at a time and runs a mark
// clear sweep over the slot the first time a row lands in its cache slot.
// When a row group completes, packing reads the stored nibbles back one at
// a time; in average mode each output nibble is the mean of four of them.
// Pixels pass the three converter stages and the two-entry queue before the
// back end. Reset empties the cache, both queues and the row counter; each
// image starts with a reset. A stalled receiver fills the four-entry output
// queue, then packing waits and the input side backs up to full.
// ----------------------------------------------------------------------------
module gray4_thumbnail_row_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [g4trp_pkg::COORD_W-1:0] pixel_x,
	input  logic [g4trp_pkg::COORD_W-1:0] pixel_y,
	input  logic [g4trp_pkg::COLOR_W-1:0] color,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    packed_byte,
	output logic                          last_of_row,
	input  logic                          cfg_we,
	input  logic [g4trp_pkg::IDX_W-1:0]   cfg_index,
	input  logic [g4trp_pkg::CFG_W-1:0]   cfg_data
);

	logic [g4trp_pkg::CW_W-1:0] width_q;
	logic [g4trp_pkg::CH_W-1:0] height_q;
	logic                       avg_q;
	g4trp_pkg::cfg_t            cfg;
	logic                       ent_valid, ent_pop, oq_full, oq_push;
	g4trp_pkg::ent_t            ent;
	g4trp_pkg::out_t            oq_wdata, oq_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= g4trp_pkg::WIDTH_RST;
			height_q <= g4trp_pkg::HEIGHT_RST;
			avg_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				g4trp_pkg::REG_WIDTH:  width_q  <= cfg_data[g4trp_pkg::CW_W-1:0];
				g4trp_pkg::REG_HEIGHT: height_q <= cfg_data[g4trp_pkg::CH_W-1:0];
				g4trp_pkg::REG_AVG:    avg_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.width  = g4trp_pkg::eff_width(width_q);
	assign cfg.height = height_q;
	assign cfg.avg    = avg_q;

	// pixel intake and gray conversion
	g4trp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.color     (color),
		.ent_valid (ent_valid),
		.ent       (ent),
		.ent_pop   (ent_pop)
	);

	// row cache and packer
	g4trp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ent_valid (ent_valid),
		.ent       (ent),
		.ent_pop   (ent_pop),
		.oq_full   (oq_full),
		.oq_push   (oq_push),
		.oq_data   (oq_wdata)
	);

	// result queue
	g4trp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (oq_push),
		.wdata  (oq_wdata),
		.full   (oq_full),
		.empty  (empty),
		.pop    (pop),
		.rdata  (oq_rdata)
	);

	assign packed_byte = oq_rdata.data;
	assign last_of_row = oq_rdata.last;

endmodule

>>> design/g4trp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g4trp_chk
// Port-level checks of the gray4 row packer, bound to the top level.
// ----------------------------------------------------------------------------
module g4trp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] packed_byte,
	input logic       last_of_row
);

	logic seen_q;

	// any item taken since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (push && !full) begin
			seen_q <= 1'b1;
		end
	end

	// no byte without some pixel first
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> empty)
		else $error("result before any item");

	// intake is open right after reset
	a_open_after_reset: assert property (@(posedge clk)
		!arst_n |=> !full)
		else $error("full right after reset");

	// waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(packed_byte) && $stable(last_of_row)))
		else $error("waiting result changed");

endmodule

bind gray4_thumbnail_row_packer g4trp_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.packed_byte (packed_byte),
	.last_of_row (last_of_row)
);
